// ----- src/wss_pkg.sv -----
// Shared types and constants for the wide substring search core.
// Used by wss_cell and wide_substring_search_core; depends on nothing else.
package wss_pkg;

  localparam int POS_BITS    = 32;
  localparam int STATUS_BITS = 2;
  localparam int IN_CHAR_BITS = 16;

  localparam logic [POS_BITS-1:0] COUNT_MAX = '1;

  // Item kinds on the input channel.
  localparam logic KIND_NEEDLE   = 1'b0;
  localparam logic KIND_HAYSTACK = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

  // Controls broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic load;   // write a needle character into the selected cell
    logic step;   // a haystack character enters the chain
    logic clear;  // drop all partial matches
  } cell_ctrl_t;

endpackage

// ----- src/wss_cell.sv -----
// One cell of the matching chain: holds one needle character and a partial-match bit.
// Depends on wss_pkg for the control struct.
module wss_cell #(
  parameter int CHAR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wss_pkg::cell_ctrl_t  ctrl,
  input  logic                 sel,
  input  logic [CHAR_BITS-1:0] load_char,
  input  logic [CHAR_BITS-1:0] hay_char,
  input  logic                 match_in,
  output logic                 match_out,
  output logic                 hit
);
  import wss_pkg::*;

  logic [CHAR_BITS-1:0] needle_char;
  logic                 match;

  // The needle prefix ending at this cell matches the text ending at the new character.
  assign hit       = match_in && (hay_char == needle_char);
  assign match_out = match;

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      needle_char <= load_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.step) begin
      match <= hit;
    end
  end

endmodule

// ----- src/wide_substring_search_core.sv -----
// Wide substring search: first match of a stored needle in a streamed haystack.
// Every item is taken on arrival unless the input is stalled; the chain updates all partial matches at once.
// The result is registered: it appears in the output register in the cycle after the terminator is taken.
// A waiting result stalls the input only while it is itself stalled.
// Synchronous reset clears the needle length, internal flags, counters and match bits.
module wide_substring_search_core #(
  parameter int MAX_NEEDLE = 32,
  parameter int CHAR_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            kind,
  input  logic [wss_pkg::IN_CHAR_BITS-1:0] char_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            found,
  output logic [wss_pkg::POS_BITS-1:0]    position,
  output logic [wss_pkg::STATUS_BITS-1:0] status
);
  import wss_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_NEEDLE + 1);
  localparam int IDX_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

  logic [CHAR_BITS-1:0] c;
  logic                 accept;
  logic                 is_zero;

  logic [LEN_BITS-1:0]  needle_length;
  logic                 needle_complete;
  logic                 needle_too_long;
  logic [POS_BITS-1:0]  haystack_count;
  logic                 match_found;
  logic [POS_BITS-1:0]  match_position;
  logic                 count_overflow;

  logic [LEN_BITS-1:0]  len_base;
  logic [LEN_BITS-1:0]  last_len;
  logic [IDX_BITS-1:0]  last_idx;
  logic [POS_BITS-1:0]  hit_position;
  cell_ctrl_t           ctrl;

  logic [MAX_NEEDLE-1:0] hit_vec;
  logic [MAX_NEEDLE-1:0] match_vec;
  logic [MAX_NEEDLE-1:0] sel_vec;

  generate
    if (CHAR_BITS > IN_CHAR_BITS) begin : g_wide
      assign c = {{(CHAR_BITS - IN_CHAR_BITS){1'b0}}, char_value};
    end else if (CHAR_BITS == IN_CHAR_BITS) begin : g_same
      assign c = char_value;
    end else begin : g_narrow
      assign c = char_value[CHAR_BITS-1:0];
    end
  endgenerate

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign is_zero    = (c == '0);

  // A needle character after a completed needle starts a fresh one.
  assign len_base = needle_complete ? '0 : needle_length;
  assign last_len = needle_length - LEN_BITS'(1);
  assign last_idx = last_len[IDX_BITS-1:0];
  assign hit_position = haystack_count + POS_BITS'(1) - POS_BITS'(needle_length);

  always_comb begin
    ctrl.load  = accept && (kind == KIND_NEEDLE) && !is_zero
                 && (len_base < LEN_BITS'(MAX_NEEDLE));
    ctrl.step  = accept && (kind == KIND_HAYSTACK) && !is_zero
                 && (haystack_count != COUNT_MAX);
    ctrl.clear = accept && (((kind == KIND_NEEDLE) && needle_complete)
                 || ((kind == KIND_HAYSTACK) && is_zero));
  end

  genvar k;
  generate
    for (k = 0; k < MAX_NEEDLE; k++) begin : g_cell
      assign sel_vec[k] = (len_base == LEN_BITS'(k));
      wss_cell #(
        .CHAR_BITS (CHAR_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .sel       (sel_vec[k]),
        .load_char (c),
        .hay_char  (c),
        .match_in  ((k == 0) ? 1'b1 : match_vec[(k > 0) ? k - 1 : 0]),
        .match_out (match_vec[k]),
        .hit       (hit_vec[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length   <= '0;
      needle_complete <= 1'b0;
      needle_too_long <= 1'b0;
      haystack_count  <= '0;
      match_found     <= 1'b0;
      match_position  <= '0;
      count_overflow  <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      // A stalled result is held; a terminator loads a new one.
      result_valid <= item_stall || (accept && (kind == KIND_HAYSTACK) && is_zero);
      if (accept) begin
        if (kind == KIND_NEEDLE) begin
          if (needle_complete) begin
            haystack_count  <= '0;
            match_found     <= 1'b0;
            match_position  <= '0;
            count_overflow  <= 1'b0;
          end
          needle_complete <= is_zero;
          if (!is_zero && (len_base < LEN_BITS'(MAX_NEEDLE))) begin
            needle_length <= len_base + LEN_BITS'(1);
          end else if (needle_complete) begin
            needle_length <= '0;
          end
          if (needle_complete) begin
            needle_too_long <= 1'b0;
          end else if (!is_zero && (len_base >= LEN_BITS'(MAX_NEEDLE))) begin
            needle_too_long <= 1'b1;
          end
        end else begin
          needle_complete <= 1'b1;
          if (!is_zero) begin
            if (haystack_count == COUNT_MAX) begin
              count_overflow <= 1'b1;
            end else begin
              haystack_count <= haystack_count + POS_BITS'(1);
              if (!match_found && (needle_length != '0) && hit_vec[last_idx]) begin
                match_found    <= 1'b1;
                match_position <= hit_position;
              end
            end
          end else begin
            // Terminator: publish the result and return the haystack side to reset.
            if (needle_too_long) begin
              found    <= 1'b0;
              position <= '0;
              status   <= STATUS_TOO_LONG;
            end else begin
              if (needle_length == '0) begin
                found    <= 1'b1;
                position <= '0;
              end else begin
                found    <= match_found;
                position <= match_found ? match_position : '0;
              end
              status <= count_overflow ? STATUS_OVERFLOW : STATUS_OK;
            end
            haystack_count <= '0;
            match_found    <= 1'b0;
            match_position <= '0;
            count_overflow <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- bench/wide_substring_search_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for wide_substring_search_core: directed and random needle/haystack streams.
// Depends on wss_pkg and the core; a scoreboard class predicts each search result and checks it.
module wide_substring_search_core_tb;
  import wss_pkg::*;

  localparam int NEEDLE_DEPTH = 32;
  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic                   found;
    logic [POS_BITS-1:0]    position;
    logic [STATUS_BITS-1:0] status;
  } search_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_style_t;

  class search_scoreboard;
    localparam int DEPTH = NEEDLE_DEPTH;
    logic [IN_CHAR_BITS-1:0] needle_chars[DEPTH];
    logic [IN_CHAR_BITS-1:0] window[DEPTH];
    int unsigned             needle_len;
    bit                      needle_closed;
    bit                      needle_overrun;
    logic [POS_BITS-1:0]     hay_count;
    logic [POS_BITS-1:0]     hit_pos;
    bit                      hit;
    bit                      count_sat;
    search_result_t          expected[$];
    int                      fail_count;

    function new();
      needle_len = 0;
      needle_closed = 0;
      needle_overrun = 0;
      fail_count = 0;
      for (int j = 0; j < DEPTH; j++) needle_chars[j] = '0;
      clear_haystack();
    endfunction

    function void clear_haystack();
      for (int j = 0; j < DEPTH; j++) window[j] = '0;
      hay_count = '0;
      hit = 0;
      hit_pos = '0;
      count_sat = 0;
    endfunction

    // Updates the search state for one accepted transfer; a haystack terminator
    // queues the result it must produce.
    function void note_item(logic k, logic [IN_CHAR_BITS-1:0] c);
      search_result_t res;
      bit             same;
      int             j;
      if (k == KIND_NEEDLE) begin
        if (needle_closed) begin
          needle_len = 0;
          needle_overrun = 0;
          needle_closed = 0;
          clear_haystack();
        end
        if (c == '0) begin
          needle_closed = 1;
        end else if (needle_len < DEPTH) begin
          needle_chars[needle_len] = c;
          needle_len++;
        end else begin
          needle_overrun = 1;
        end
      end else begin
        needle_closed = 1;
        if (c != '0) begin
          if (hay_count == COUNT_MAX) begin
            count_sat = 1;
          end else begin
            for (j = DEPTH - 1; j > 0; j--) window[j] = window[j-1];
            window[0] = c;
            hay_count++;
            if (!hit && needle_len > 0 && hay_count >= needle_len) begin
              same = 1;
              // The newest window entry lines up with the last needle character.
              for (j = 0; j < needle_len; j++)
                if (window[j] != needle_chars[needle_len-1-j]) same = 0;
              if (same) begin
                hit = 1;
                hit_pos = hay_count - needle_len;
              end
            end
          end
        end else begin
          res.found = 1'b0;
          res.position = '0;
          res.status = STATUS_OK;
          if (needle_overrun) begin
            res.status = STATUS_TOO_LONG;
          end else begin
            if (needle_len == 0) begin
              res.found = 1'b1;
            end else if (hit) begin
              res.found = 1'b1;
              res.position = hit_pos;
            end
            if (count_sat) res.status = STATUS_OVERFLOW;
          end
          expected.push_back(res);
          clear_haystack();
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t: %s", $time, what);
      fail_count++;
    endtask

    task check_result(logic f, logic [POS_BITS-1:0] p, logic [STATUS_BITS-1:0] s);
      search_result_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result: found %0b position %0d status %0d",
                                  f, p, s));
      end else begin
        want = expected.pop_front();
        if (f !== want.found)
          report_mismatch($sformatf("found is %0b, expected %0b", f, want.found));
        if (p !== want.position)
          report_mismatch($sformatf("position is %0d, expected %0d", p, want.position));
        if (s !== want.status)
          report_mismatch($sformatf("status is %0d, expected %0d", s, want.status));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic                    kind = KIND_NEEDLE;
  logic [IN_CHAR_BITS-1:0] char_value = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    found;
  logic [POS_BITS-1:0]     position;
  logic [STATUS_BITS-1:0]  status;

  search_scoreboard sb;

  int           burst_left = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  int           mode_left = 0;
  stall_style_t stall_mode = STALL_NONE;

  wide_substring_search_core #(
    .MAX_NEEDLE(NEEDLE_DEPTH),
    .CHAR_BITS (IN_CHAR_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .char_value  (char_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found       (found),
    .position    (position),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one character; the sender runs in bursts with idle gaps between them.
  task automatic send_char(input logic k, input logic [IN_CHAR_BITS-1:0] c);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    item_valid <= 1'b1;
    kind <= k;
    char_value <= c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(k, c);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // Empty needle straight after reset, against an empty haystack.
    send_char(KIND_HAYSTACK, '0);
    // Needle of extreme codes, found one character into the haystack.
    send_char(KIND_NEEDLE, 16'hFFFF);
    send_char(KIND_NEEDLE, 16'h0001);
    send_char(KIND_NEEDLE, '0);
    send_char(KIND_HAYSTACK, 16'h0001);
    send_char(KIND_HAYSTACK, 16'hFFFF);
    send_char(KIND_HAYSTACK, 16'h0001);
    send_char(KIND_HAYSTACK, '0);
    // The needle is kept; this haystack is shorter than it.
    send_char(KIND_HAYSTACK, 16'hFFFF);
    send_char(KIND_HAYSTACK, '0);
    // An explicitly empty needle matches at the start.
    send_char(KIND_NEEDLE, '0);
    send_char(KIND_HAYSTACK, 16'h1234);
    send_char(KIND_HAYSTACK, '0);
    // A needle left open is closed by the first haystack character.
    send_char(KIND_NEEDLE, 16'h8000);
    send_char(KIND_HAYSTACK, 16'h8000);
    send_char(KIND_HAYSTACK, '0);
    // A new needle in the middle of a haystack throws away the earlier match.
    send_char(KIND_NEEDLE, 16'h0005);
    send_char(KIND_NEEDLE, '0);
    send_char(KIND_HAYSTACK, 16'h0005);
    send_char(KIND_NEEDLE, 16'h7FFE);
    send_char(KIND_HAYSTACK, 16'h0005);
    send_char(KIND_HAYSTACK, 16'h7FFE);
    send_char(KIND_HAYSTACK, '0);
  endtask

  task automatic run_random(input int count);
    logic [IN_CHAR_BITS-1:0] letters[4];
    logic [IN_CHAR_BITS-1:0] needle_buf[NEEDLE_DEPTH+8];
    logic [IN_CHAR_BITS-1:0] c;
    int                      stop_at;
    int                      nlen;
    int                      hay_len;
    int                      plant_at;
    int                      searches;
    int                      shape;
    int                      i;
    int                      j;
    bit                      force_long;
    stop_at = items_sent + count;
    force_long = 1;
    while (items_sent < stop_at) begin
      // A small alphabet keeps partial and full matches frequent.
      for (i = 0; i < 4; i++) letters[i] = IN_CHAR_BITS'($urandom_range(1, 16'hFFFF));
      shape = $urandom_range(0, 19);
      if (force_long || shape == 0) nlen = $urandom_range(NEEDLE_DEPTH + 1, NEEDLE_DEPTH + 4);
      else if (shape < 3) nlen = 0;
      else if (shape < 6) nlen = $urandom_range(7, NEEDLE_DEPTH);
      else nlen = $urandom_range(1, 6);
      force_long = 0;
      for (i = 0; i < nlen; i++) begin
        needle_buf[i] = letters[$urandom_range(0, 3)];
        send_char(KIND_NEEDLE, needle_buf[i]);
      end
      // Now and then the haystack itself has to close the needle.
      if (shape != 7) send_char(KIND_NEEDLE, '0);
      searches = $urandom_range(1, 3);
      for (j = 0; j < searches; j++) begin
        if (nlen > 6) hay_len = $urandom_range(nlen - 4, nlen + 12);
        else hay_len = $urandom_range(0, 16);
        plant_at = -1;
        if (nlen > 0 && hay_len >= nlen && $urandom_range(0, 2) != 0)
          plant_at = $urandom_range(0, hay_len - nlen);
        for (i = 0; i < hay_len; i++) begin
          if (plant_at >= 0 && i >= plant_at && i < plant_at + nlen)
            c = needle_buf[i - plant_at];
          else if ($urandom_range(0, 9) == 0)
            c = IN_CHAR_BITS'($urandom_range(1, 16'hFFFF));
          else
            c = letters[$urandom_range(0, 3)];
          send_char(KIND_HAYSTACK, c);
          // Rarely a needle character breaks in and restarts the needle.
          if ($urandom_range(0, 199) == 0)
            send_char(KIND_NEEDLE, $urandom_range(0, 1) ? letters[0] : '0);
        end
        send_char(KIND_HAYSTACK, '0);
      end
      if ($urandom_range(0, 24) == 0) wait_results_drained();
    end
  endtask

  // Result side: checks each transfer and stalls in styles that change over time.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(found, position, status);
    if (mode_left == 0) begin
      stall_mode = stall_style_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        result_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        result_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        result_stall <= ((mode_left % 16) < 11);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // Hold the sender until every pending result has come back.
    wait_results_drained();
    run_random(RANDOM_ITEMS);
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
